### rtl/core/tpaf_pkg.sv
// Shared types and constants for the thyristor phase-angle firing controller.
package tpaf_pkg;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_TARGET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SLEW       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_ALPHA = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT       = 2'd3;

	// Fixed-point constants
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;   // 1.0 in Q1.16
	localparam logic [16:0] TRANS_RESET = 17'd39322;   // 0.6 in Q1.16
	localparam logic [15:0] EMA_W_RESET = 16'd13107;   // 0.2 in Q0.16
	localparam logic [23:0] AVG_RESET   = 24'd2560000; // 10000 us in Q16.8

	// Counter width and bit counts of the serial multiplier passes
	localparam int MUL_CNT_W  = 5;
	localparam int EMA_STEPS  = 16;
	localparam int SLEW_STEPS = 16;
	localparam int DLY_STEPS  = 17;

	// Arm channel codes
	localparam logic [1:0] ARM_NONE   = 2'd0;
	localparam logic [1:0] ARM_DRIVE0 = 2'd1;
	localparam logic [1:0] ARM_DRIVE1 = 2'd2;

	// Request opcodes
	typedef enum logic [2:0] {
		OP_RISE = 3'd0,
		OP_FALL = 3'd1,
		OP_CMP0 = 3'd2,
		OP_CMP1 = 3'd3,
		OP_SNAP = 3'd4
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMA_LOAD,
		ST_EMA,
		ST_SLEW,
		ST_DLY_LOAD,
		ST_DLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] capture_time;
	} cmd_t;

	typedef struct packed {
		logic        drive0_on;
		logic        drive1_on;
		logic [1:0]  arm_channel;
		logic [15:0] compare_time;
		logic [16:0] alpha_now;
		logic        locked;
	} res_t;

endpackage

### rtl/core/thyristor_phase_angle_firing.sv
// Thyristor phase-angle firing controller with soft-start angle ramp.
// Compare events, snap and the first (locking) edge go from accept straight to the completion state.
// A locked edge runs the shared bit-serial multiplier, one multiplier bit per cycle, over an EMA
// pass (16 bits) and a slew pass (16 bits), plus a delay pass (17 bits) when a compare is armed.
// A new request is accepted only after the previous one has committed its result.
// Reset (async, active low) restores register defaults, unlocked phase, gates off, angle zero.
module thyristor_phase_angle_firing
	import tpaf_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CAP_W = (TIMER_BITS < 16) ? TIMER_BITS : 16;

	// Configuration registers
	logic [16:0] alpha_target_q;
	logic [31:0] alpha_slew_q;
	logic [16:0] trans_alpha_q;
	logic [15:0] ema_weight_q;

	// Controller state
	logic [16:0]           alpha_q;
	logic [TIMER_BITS-1:0] last_edge_q;
	logic [23:0]           pos_avg_q;
	logic [23:0]           neg_avg_q;
	logic                  locked_q;
	logic                  pend0_q;
	logic                  pend1_q;
	logic                  gate0_q;
	logic                  gate1_q;

	// Request in flight
	logic [2:0]            op_q;
	logic [TIMER_BITS-1:0] cap_q;
	logic [15:0]           period_q;
	logic [1:0]            arm_q;
	logic [15:0]           cmp_q;

	// Serial multiplier
	logic [33:0]          acc_q;
	logic [32:0]          mcand_q;
	logic [16:0]          mplier_q;
	logic [MUL_CNT_W-1:0] cnt_q;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	res_t   res_q;

	logic                  accept;
	logic                  res_free;
	logic                  commit;
	logic                  mul_last;
	logic                  cmd_is_edge;
	logic                  rising_q;
	logic [TIMER_BITS-1:0] cap_tb;
	logic [TIMER_BITS-1:0] diff_tb;
	logic [TIMER_BITS+15:0] diff_x;
	logic [15:0]           period_sat;
	logic [23:0]           avg_same;
	logic [23:0]           avg_other;
	logic signed [24:0]    ema_diff;
	logic [34:0]           mul_sum;
	logic [33:0]           acc_next;
	logic [23:0]           ema_new;
	logic [16:0]           tsat;
	logic [32:0]           alpha_sum;
	logic [16:0]           alpha_inc;
	logic                  below_trans;
	logic [16:0]           dly_mult;
	logic [TIMER_BITS+16:0] cmp_sum;
	logic [TIMER_BITS+15:0] cmp_x;
	logic [15:0]           cmp16;

	// Commit values
	logic [16:0]           alpha_d;
	logic [TIMER_BITS-1:0] last_d;
	logic                  locked_d;
	logic                  pend0_d;
	logic                  pend1_d;
	logic                  gate0_d;
	logic                  gate1_d;

	assign accept      = cmd_valid && cmd_ready;
	assign res_free    = !res_valid_q || res_ready;
	assign mul_last    = (cnt_q == '0);
	assign cmd_is_edge = (cmd.opcode == OP_RISE) || (cmd.opcode == OP_FALL);
	assign rising_q    = (op_q == OP_RISE);

	// Capture narrowed or widened to the timer width
	assign cap_tb = TIMER_BITS'(cmd.capture_time[CAP_W-1:0]);

	// Half period, saturated to 16 bits
	assign diff_tb    = cap_q - last_edge_q;
	assign diff_x     = {16'b0, diff_tb};
	assign period_sat = (|diff_x[TIMER_BITS+15:16]) ? 16'hFFFF : diff_x[15:0];

	// Rising edge refreshes the negative half average and times off the positive one
	assign avg_same  = rising_q ? neg_avg_q : pos_avg_q;
	assign avg_other = rising_q ? pos_avg_q : neg_avg_q;

	// EMA as avg + (sample - avg) * w / 2^16
	assign ema_diff = $signed({1'b0, period_sat, 8'b0}) - $signed({1'b0, avg_same});

	// One multiplier bit per cycle; the right shift keeps the floor of the scaled product
	assign mul_sum  = {acc_q[33], acc_q} + (mplier_q[0] ? {{2{mcand_q[32]}}, mcand_q} : 35'd0);
	assign acc_next = mul_sum[34:1];

	assign ema_new = avg_same + acc_next[23:0];

	// Angle ramp with saturation at 1.0
	assign tsat      = (alpha_target_q > ALPHA_ONE) ? ALPHA_ONE : alpha_target_q;
	assign alpha_sum = {16'b0, alpha_q} + {1'b0, acc_next[31:0]};
	assign alpha_inc = (alpha_sum > {16'b0, ALPHA_ONE}) ? ALPHA_ONE : alpha_sum[16:0];

	assign below_trans = (alpha_q < trans_alpha_q);
	assign dly_mult    = ALPHA_ONE - alpha_q;

	// Compare time: capture plus delay (product over 2^17, then 7 more bits dropped)
	assign cmp_sum = (TIMER_BITS+17)'(cap_q) + (TIMER_BITS+17)'(acc_next[23:7]);
	assign cmp_x   = {16'b0, cmp_sum[TIMER_BITS-1:0]};
	assign cmp16   = cmp_x[15:0];

	// Sequencer next state
	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					if (cmd_is_edge && locked_q) begin
						state_d = ST_EMA_LOAD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_EMA_LOAD: begin
				state_d = ST_EMA;
			end
			ST_EMA: begin
				if (mul_last) begin
					state_d = ST_SLEW;
				end
			end
			ST_SLEW: begin
				if (mul_last) begin
					state_d = ST_DLY_LOAD;
				end
			end
			ST_DLY_LOAD: begin
				state_d = below_trans ? ST_DLY : ST_DONE;
			end
			ST_DLY: begin
				if (mul_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Final state update of a request
	always_comb begin
		alpha_d  = alpha_q;
		last_d   = last_edge_q;
		locked_d = locked_q;
		pend0_d  = pend0_q;
		pend1_d  = pend1_q;
		gate0_d  = gate0_q;
		gate1_d  = gate1_q;
		case (op_q)
			OP_RISE, OP_FALL: begin
				last_d = cap_q;
				if (!locked_q) begin
					locked_d = 1'b1;
				end else begin
					pend0_d = 1'b0;
					pend1_d = 1'b0;
					if (arm_q != ARM_NONE) begin
						if (rising_q) begin
							gate1_d = 1'b0;
							pend0_d = 1'b1;
						end else begin
							gate0_d = 1'b0;
							pend1_d = 1'b1;
						end
					end else if (rising_q) begin
						gate0_d = 1'b1;
					end else begin
						gate1_d = 1'b1;
					end
				end
			end
			OP_CMP0: begin
				if (pend0_q) begin
					pend0_d = 1'b0;
					gate0_d = 1'b1;
				end
			end
			OP_CMP1: begin
				if (pend1_q) begin
					pend1_d = 1'b0;
					gate1_d = 1'b1;
				end
			end
			OP_SNAP: begin
				alpha_d = tsat;
			end
			default: begin
			end
		endcase
	end

	// Configuration, controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_target_q <= '0;
			alpha_slew_q   <= '0;
			trans_alpha_q  <= TRANS_RESET;
			ema_weight_q   <= EMA_W_RESET;
			alpha_q        <= '0;
			last_edge_q    <= '0;
			pos_avg_q      <= AVG_RESET;
			neg_avg_q      <= AVG_RESET;
			locked_q       <= 1'b0;
			pend0_q        <= 1'b0;
			pend1_q        <= 1'b0;
			gate0_q        <= 1'b0;
			gate1_q        <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA_TARGET:     alpha_target_q <= cfg_wdata[16:0];
					REG_ALPHA_SLEW:       alpha_slew_q   <= cfg_wdata;
					REG_TRANSITION_ALPHA: trans_alpha_q  <= cfg_wdata[16:0];
					REG_EMA_WEIGHT:       ema_weight_q   <= cfg_wdata[15:0];
					default: begin
					end
				endcase
			end
			// end of the EMA pass
			if ((state_q == ST_EMA) && mul_last) begin
				if (rising_q) begin
					neg_avg_q <= ema_new;
				end else begin
					pos_avg_q <= ema_new;
				end
			end
			// end of the slew pass: ramp only while below target
			if ((state_q == ST_SLEW) && mul_last && (tsat > alpha_q)) begin
				alpha_q <= alpha_inc;
			end
			// at or above the transition angle: snap to target
			if ((state_q == ST_DLY_LOAD) && !below_trans) begin
				alpha_q <= tsat;
			end
			if (commit) begin
				alpha_q     <= alpha_d;
				last_edge_q <= last_d;
				locked_q    <= locked_d;
				pend0_q     <= pend0_d;
				pend1_q     <= pend1_d;
				gate0_q     <= gate0_d;
				gate1_q     <= gate1_d;
			end
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, multiplier datapath and result register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= cmd.opcode;
					cap_q <= cap_tb;
					arm_q <= ARM_NONE;
					cmp_q <= '0;
				end
			end
			ST_EMA_LOAD: begin
				period_q <= period_sat;
				acc_q    <= '0;
				mcand_q  <= {{8{ema_diff[24]}}, ema_diff};
				mplier_q <= {1'b0, ema_weight_q};
				cnt_q    <= MUL_CNT_W'(EMA_STEPS - 1);
			end
			ST_EMA: begin
				if (mul_last) begin
					acc_q    <= '0;
					mcand_q  <= {1'b0, alpha_slew_q};
					mplier_q <= {1'b0, period_q};
					cnt_q    <= MUL_CNT_W'(SLEW_STEPS - 1);
				end else begin
					acc_q    <= acc_next;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			ST_SLEW: begin
				if (!mul_last) begin
					acc_q    <= acc_next;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			ST_DLY_LOAD: begin
				acc_q    <= '0;
				mcand_q  <= {9'b0, avg_other};
				mplier_q <= dly_mult;
				cnt_q    <= MUL_CNT_W'(DLY_STEPS - 1);
				if (below_trans) begin
					arm_q <= rising_q ? ARM_DRIVE0 : ARM_DRIVE1;
				end
			end
			ST_DLY: begin
				if (mul_last) begin
					cmp_q <= cmp16;
				end else begin
					acc_q    <= acc_next;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (commit) begin
					res_q.drive0_on    <= gate0_d;
					res_q.drive1_on    <= gate1_d;
					res_q.arm_channel  <= arm_q;
					res_q.compare_time <= cmp_q;
					res_q.alpha_now    <= alpha_d;
					res_q.locked       <= locked_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		alpha_q <= ALPHA_ONE)
		else $error("firing angle above 1.0");

	a_pend_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend0_q && pend1_q))
		else $error("both drives pending");

	a_arm_locked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.arm_channel != ARM_NONE) |-> res_q.locked)
		else $error("compare armed while unlocked");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.arm_channel == ARM_NONE) |-> (res_q.compare_time == '0))
		else $error("compare time set without armed channel");

	a_armed_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.arm_channel == ARM_DRIVE0) |-> pend0_q)
		else $error("drive0 armed but not pending");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside completion");

endmodule
